// ----- rtl/chh_pkg.sv -----
package chh_pkg;

  // cordic configuration
  localparam int CORDIC_ITERATIONS = 16;
  localparam int TBL_LEN = 24;
  localparam int TBL_IW = 5;
  localparam int CNT_W = $clog2(CORDIC_ITERATIONS);

  // datapath widths: vector magnitude grows by the cordic gain, angle stays below 2^19
  localparam int XW = 20;
  localparam int AW = 20;
  localparam int DEG_W = 9;

  localparam logic signed [AW-1:0] HALF_PI_Q16 = AW'(102944);

  // degrees = floor(floor(|z| * 1125 / 2^13) / 157), sign restored afterwards
  localparam int DEG_MUL = 1125;
  localparam int DEG_SHIFT = 13;
  localparam int DEG_DIV = 157;
  localparam int RECIP = 6678;
  localparam int RECIP_SHIFT = 20;
  localparam int MUL1_W = AW + 11;
  localparam int P_W = MUL1_W - DEG_SHIFT;
  localparam int MUL2_W = P_W + 13;
  localparam int Q_W = MUL2_W - RECIP_SHIFT;
  localparam int DEG_MAX = 180;

  // configuration registers
  localparam logic [15:0] X_OFFSET_RST = 16'hFFCE;
  localparam logic [15:0] Y_OFFSET_RST = 16'd280;
  localparam logic [15:0] HOLDOFF_RST = 16'd300;

  typedef enum logic [1:0] {
    CFG_X_OFFSET = 2'd0,
    CFG_Y_OFFSET = 2'd1,
    CFG_HOLDOFF  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
    logic [7:0]  byte4;
    logic [7:0]  byte5;
    logic [31:0] now_ms;
  } frame_t;

  typedef struct packed {
    logic signed [DEG_W-1:0] heading_deg;
    logic                    updated;
    logic signed [15:0]      x_corrected;
    logic signed [15:0]      y_corrected;
    logic signed [15:0]      z_value;
  } result_t;

  typedef struct packed {
    logic                 done;
    logic signed [AW-1:0] angle;
  } cordic_status_t;

  // round(atan(2^-i) * 65536)
  function automatic logic [15:0] atan_q16(input logic [TBL_IW-1:0] i);
    logic [15:0] v;
    case (i)
      5'd0:    v = 16'd51472;
      5'd1:    v = 16'd30386;
      5'd2:    v = 16'd16055;
      5'd3:    v = 16'd8150;
      5'd4:    v = 16'd4091;
      5'd5:    v = 16'd2047;
      5'd6:    v = 16'd1024;
      5'd7:    v = 16'd512;
      5'd8:    v = 16'd256;
      5'd9:    v = 16'd128;
      5'd10:   v = 16'd64;
      5'd11:   v = 16'd32;
      5'd12:   v = 16'd16;
      5'd13:   v = 16'd8;
      5'd14:   v = 16'd4;
      5'd15:   v = 16'd2;
      5'd16:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/compass_heading_holdoff.sv -----
// compass heading with update hold-off
//
// frame channel (frame_valid / frame_stall / frame): one magnetometer frame
// of six raw bytes plus a millisecond timestamp per item. x is bytes 0-1,
// z bytes 2-3, y bytes 4-5, big-endian. offsets are added to x and y.
// result channel (result_valid / result_stall / result): one item per frame
// with the heading in degrees, the updated flag and the corrected axes.
// cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): x_offset,
// y_offset, holdoff_ms; always ready, unknown indexes are dropped.
// a frame whose timestamp is within holdoff_ms of the last update returns
// the held heading without running the cordic. otherwise atan2 runs on the
// iterative cordic unit, one micro-rotation per cycle, then a three stage
// degree conversion.
// one frame is in work at a time; frame_stall is high while it is.
// while the receiver stalls, the result register holds its item and a
// finished frame waits for it; no new frame is taken meanwhile.
// reset (rst, synchronous) restores the default offsets and hold-off and
// clears the held heading and last update time to zero.
module compass_heading_holdoff (
  input  logic             clk,
  input  logic             rst,
  input  logic             frame_valid,
  output logic             frame_stall,
  input  chh_pkg::frame_t  frame,
  output logic             result_valid,
  input  logic             result_stall,
  output chh_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data
);
  import chh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_CORDIC,
    S_DEG,
    S_EMIT
  } state_t;

  state_t state;

  // configuration
  logic [15:0] x_offset, y_offset, holdoff_ms;

  // state carried between frames
  logic [31:0]             last_update_ms;
  logic signed [DEG_W-1:0] held_heading;

  // the frame in work
  logic signed [15:0] item_x, item_y, item_z;
  logic [31:0]        item_now;
  logic               item_upd;

  logic               frame_accept;
  logic [15:0]        xc, yc;
  logic [31:0]        diff;
  logic               upd;
  logic               result_load;

  cordic_status_t          cordic_status;
  logic                    deg_done;
  logic signed [DEG_W-1:0] deg;

  assign cfg_ready    = 1'b1;
  assign frame_stall  = (state != S_IDLE);
  assign frame_accept = frame_valid && !frame_stall;
  assign result_load  = (state == S_EMIT) && (!result_valid || !result_stall);

  always_comb begin
    xc   = {frame.byte0, frame.byte1} + x_offset;
    yc   = {frame.byte4, frame.byte5} + y_offset;
    // signed wrapping difference, negative counts as too soon
    diff = frame.now_ms - last_update_ms;
    upd  = !diff[31] && (diff >= {16'd0, holdoff_ms});
  end

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      x_offset   <= X_OFFSET_RST;
      y_offset   <= Y_OFFSET_RST;
      holdoff_ms <= HOLDOFF_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_X_OFFSET: x_offset   <= cfg_data;
        CFG_Y_OFFSET: y_offset   <= cfg_data;
        CFG_HOLDOFF:  holdoff_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // single cordic unit, started in the cycle after the frame is latched
  chh_cordic u_cordic (
    .clk    (clk),
    .rst    (rst),
    .start  (state == S_START),
    .x_in   (item_x),
    .y_in   (item_y),
    .status (cordic_status)
  );

  // radians in q4.16 to whole degrees
  chh_deg u_deg (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_status.done),
    .angle (cordic_status.angle),
    .done  (deg_done),
    .deg   (deg)
  );

  // sequencer, heading state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      result_valid   <= 1'b0;
      last_update_ms <= '0;
      held_heading   <= '0;
    end else begin
      // taken item leaves unless a new one replaces it in the same cycle
      if (result_valid && !result_stall && !result_load) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (frame_accept) begin
            item_x   <= xc;
            item_y   <= yc;
            item_z   <= {frame.byte2, frame.byte3};
            item_now <= frame.now_ms;
            item_upd <= upd;
            state    <= upd ? S_START : S_EMIT;
          end
        end
        S_START: state <= S_CORDIC;
        S_CORDIC: begin
          if (cordic_status.done) begin
            state <= S_DEG;
          end
        end
        S_DEG: begin
          if (deg_done) begin
            held_heading   <= deg;
            last_update_ms <= item_now;
            state          <= S_EMIT;
          end
        end
        S_EMIT: begin
          // wait for the result register to free up
          if (result_load) begin
            result_valid       <= 1'b1;
            result.heading_deg <= held_heading;
            result.updated     <= item_upd;
            result.x_corrected <= item_x;
            result.y_corrected <= item_y;
            result.z_value     <= item_z;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the cordic only finishes while the sequencer waits for it
  a_cordic_done_in_state: assert property (@(posedge clk) disable iff (rst)
    cordic_status.done |-> state == S_CORDIC)
    else $error("cordic finished outside its wait state");

  a_deg_done_in_state: assert property (@(posedge clk) disable iff (rst)
    deg_done |-> state == S_DEG)
    else $error("degree conversion finished outside its wait state");

  // a frame past the hold-off starts the cordic next
  a_update_starts_cordic: assert property (@(posedge clk) disable iff (rst)
    (frame_accept && upd) |=> state == S_START)
    else $error("updating frame did not start the cordic");

  // the held heading stays within half a turn
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    (held_heading <= DEG_W'(DEG_MAX)) && (held_heading >= -DEG_W'(DEG_MAX)))
    else $error("held heading out of range");

endmodule

// ----- rtl/chh_cordic.sv -----
module chh_cordic (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [15:0]    x_in,
  input  logic signed [15:0]    y_in,
  output chh_pkg::cordic_status_t status
);
  import chh_pkg::*;

  logic signed [XW-1:0] x, y;
  logic signed [AW-1:0] z;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic                 zero_vec;
  logic                 done;

  logic signed [XW-1:0] xs, ys, dx, dy;
  logic signed [AW-1:0] step_angle;

  always_comb begin
    xs = XW'(x_in);
    ys = XW'(y_in);
    dx = y >>> cnt;
    dy = x >>> cnt;
    step_angle = AW'(atan_q16(TBL_IW'(cnt)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        zero_vec <= (x_in == 16'sd0) && (y_in == 16'sd0);
        // pre-rotate into the right half plane
        if (x_in < 0) begin
          if (y_in >= 0) begin
            x <= ys;
            y <= -xs;
            z <= HALF_PI_Q16;
          end else begin
            x <= -ys;
            y <= xs;
            z <= -HALF_PI_Q16;
          end
        end else begin
          x <= xs;
          y <= ys;
          z <= '0;
        end
      end else if (busy) begin
        if (y >= 0) begin
          x <= x + dx;
          y <= y - dy;
          z <= z + step_angle;
        end else begin
          x <= x - dx;
          y <= y + dy;
          z <= z - step_angle;
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(CORDIC_ITERATIONS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status.done  = done;
  assign status.angle = zero_vec ? '0 : z;

endmodule

// ----- rtl/chh_deg.sv -----
module chh_deg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [chh_pkg::AW-1:0] angle,
  output logic                          done,
  output logic signed [chh_pkg::DEG_W-1:0] deg
);
  import chh_pkg::*;

  logic              v1, v2;
  logic              neg1, neg2;
  logic [P_W-1:0]    p1, p2;
  logic [Q_W-1:0]    q0;

  logic [AW-1:0]     mag;
  logic [MUL1_W-1:0] prod1;
  logic [MUL2_W-1:0] prod2;
  logic [P_W-1:0]    rem;
  logic [Q_W-1:0]    q, qc;

  always_comb begin
    mag   = (angle < 0) ? AW'(-angle) : AW'(angle);
    prod1 = MUL1_W'(mag) * MUL1_W'(DEG_MUL);
    prod2 = MUL2_W'(p1) * MUL2_W'(RECIP);
    rem   = p2 - P_W'(q0) * P_W'(DEG_DIV);
    q     = (rem >= P_W'(DEG_DIV)) ? q0 + 1'b1 : q0;
    qc    = (q > Q_W'(DEG_MAX)) ? Q_W'(DEG_MAX) : q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      done <= v2;
    end
    neg1 <= angle < 0;
    p1   <= prod1[MUL1_W-1:DEG_SHIFT];
    neg2 <= neg1;
    p2   <= p1;
    q0   <= prod2[MUL2_W-1:RECIP_SHIFT];
    deg  <= neg2 ? -DEG_W'(qc) : DEG_W'(qc);
  end

endmodule

// ----- test/compass_heading_holdoff_tb.sv -----
module compass_heading_holdoff_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import chh_pkg::*;

  // unused register index, the block drops writes to it
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // degrees = trunc(angle * 180 / 3.14 / 65536)
  localparam longint DEG_NUM = 64'sd9000;
  localparam longint DEG_DEN = 64'sd157 * 64'sd65536;

  localparam int HOLD_CYCLES = 400;   // long receiver hold-off for back-pressure
  localparam int QUIET_LIMIT = 4000;  // cycles with no handshake before giving up
  localparam int SETTLE_CYCLES = 30;  // idle margin after the last result is taken

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic frame_valid = 1'b0;
  logic frame_stall;
  frame_t frame = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  compass_heading_holdoff i_dut (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame        (frame),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // heading predictor: its own copy of the registers and the hold-off state
  // ---------------------------------------------------------------------------
  logic [15:0] model_x_off;
  logic [15:0] model_y_off;
  logic [15:0] model_holdoff;
  logic [31:0] last_update_ms;
  logic signed [DEG_W-1:0] held_deg;

  // round(atan(2^-i) * 65536), q4.16 radians
  int atan_steps [24] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                          256, 128, 64, 32, 16, 8, 4, 2,
                          1, 0, 0, 0, 0, 0, 0, 0};

  // vectoring cordic, angle in q4.16 radians
  function automatic int cordic_angle(int y_in, int x_in);
    int x;
    int y;
    int z;
    int dx;
    int dy;
    x = x_in;
    y = y_in;
    z = 0;
    // zero vector has no direction, report zero
    if (x == 0 && y == 0)
      return 0;
    // left half plane: pre-rotate by a quarter turn into the right half
    if (x < 0) begin
      if (y >= 0) begin
        x = y;
        y = -x_in;
        z = int'(HALF_PI_Q16);
      end else begin
        x = -y;
        y = x_in;
        z = -int'(HALF_PI_Q16);
      end
    end
    for (int i = 0; i < CORDIC_ITERATIONS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + atan_steps[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - atan_steps[i];
      end
    end
    return z;
  endfunction

  // expected result of one frame, advances the hold-off state
  function automatic result_t predict_heading(frame_t f);
    result_t r;
    logic [15:0] xc;
    logic [15:0] yc;
    logic [31:0] since;
    int angle;
    longint deg;
    xc = {f.byte0, f.byte1} + model_x_off;
    yc = {f.byte4, f.byte5} + model_y_off;
    // signed wrapping difference; a clock going backwards is held
    since = f.now_ms - last_update_ms;
    r.updated = !since[31] && (since >= {16'd0, model_holdoff});
    if (r.updated) begin
      angle = cordic_angle(int'($signed(yc)), int'($signed(xc)));
      deg = (longint'(angle) * DEG_NUM) / DEG_DEN;
      if (deg > DEG_MAX)
        deg = DEG_MAX;
      if (deg < -DEG_MAX)
        deg = -DEG_MAX;
      held_deg = DEG_W'(deg);
      last_update_ms = f.now_ms;
    end
    r.heading_deg = held_deg;
    r.x_corrected = xc;
    r.y_corrected = yc;
    r.z_value = {f.byte2, f.byte3};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // frame driver: offers items from the pending queue, idles at random
  // ---------------------------------------------------------------------------
  frame_t frames_q [$];
  int frames_offered = 0;
  int frames_accepted = 0;
  int send_idle_pct = 0;

  always @(negedge clk) begin : drive_frames
    frame_t nxt_frame;
    logic nxt_valid;
    nxt_frame = frame;
    nxt_valid = frame_valid;
    // new item only once the one on offer has been taken
    if (!rst && frames_offered == frames_accepted) begin
      nxt_valid = 1'b0;
      if (frames_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt_frame = frames_q.pop_front();
        nxt_valid = 1'b1;
        frames_offered++;
      end
    end
    frame_valid <= nxt_valid;
    frame <= nxt_frame;
  end

  // ---------------------------------------------------------------------------
  // result receiver: random stalls plus an occasional long hold-off
  // ---------------------------------------------------------------------------
  int stall_pct = 0;
  int hold_requests = 0;
  int holds_started = 0;
  int hold_left = 0;

  always @(negedge clk) begin : drive_result_stall
    if (holds_started != hold_requests) begin
      holds_started++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on frame acceptance, checks on result acceptance
  // ---------------------------------------------------------------------------
  result_t headings_due [$];
  int mismatches = 0;
  int quiet_cycles = 0;

  task automatic compare_field(string name, int want_v, int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    logic moved;
    moved = 1'b0;
    if (rst) begin
      model_x_off = X_OFFSET_RST;
      model_y_off = Y_OFFSET_RST;
      model_holdoff = HOLDOFF_RST;
      last_update_ms = '0;
      held_deg = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        case (cfg_index)
          CFG_X_OFFSET: model_x_off = cfg_data;
          CFG_Y_OFFSET: model_y_off = cfg_data;
          CFG_HOLDOFF:  model_holdoff = cfg_data;
          default: ;
        endcase
      end
      if (frame_valid && !frame_stall) begin
        moved = 1'b1;
        headings_due.push_back(predict_heading(frame));
        frames_accepted++;
      end
      if (result_valid && !result_stall) begin
        moved = 1'b1;
        if (headings_due.size() == 0) begin
          $error("result item with no frame waiting");
          mismatches++;
        end else begin
          want = headings_due.pop_front();
          compare_field("heading_deg", int'(want.heading_deg), int'(result.heading_deg));
          compare_field("updated", int'(want.updated), int'(result.updated));
          compare_field("x_corrected", int'(want.x_corrected), int'(result.x_corrected));
          compare_field("y_corrected", int'(want.y_corrected), int'(result.y_corrected));
          compare_field("z_value", int'(want.z_value), int'(result.z_value));
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  logic [15:0] stim_x_off = X_OFFSET_RST;
  logic [15:0] stim_y_off = Y_OFFSET_RST;
  logic [15:0] stim_holdoff = HOLDOFF_RST;
  logic [31:0] stamp_ms = '0;

  // register write, only issued while nothing is in flight
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // x, z, y as signed axes, packed big-endian into the frame bytes
  task automatic queue_frame(logic [15:0] x, logic [15:0] z, logic [15:0] y,
                             logic [31:0] now);
    frame_t f;
    {f.byte0, f.byte1} = x;
    {f.byte2, f.byte3} = z;
    {f.byte4, f.byte5} = y;
    f.now_ms = now;
    frames_q.push_back(f);
  endtask

  function automatic logic [15:0] random_axis();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(64)) - 16'd32;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic queue_random_frame();
    logic [15:0] x;
    logic [15:0] y;
    x = random_axis();
    y = random_axis();
    // cancel the offset now and then to land on an axis
    if ($urandom_range(15) == 0)
      x = -stim_x_off;
    if ($urandom_range(15) == 0)
      y = -stim_y_off;
    case ($urandom_range(9))
      0: stamp_ms = $urandom();                          // jump anywhere
      1: stamp_ms = stamp_ms - $urandom_range(1000);     // clock going backwards
      2: stamp_ms = stamp_ms + stim_holdoff;             // right at the boundary
      default: stamp_ms = stamp_ms + $urandom_range(2 * int'(stim_holdoff) + 2);
    endcase
    queue_frame(x, random_axis(), y, stamp_ms);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (frames_q.size() != 0 || frames_offered != frames_accepted ||
           headings_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_regs(logic [15:0] xo, logic [15:0] yo, logic [15:0] hold);
    write_reg(CFG_X_OFFSET, xo);
    write_reg(CFG_Y_OFFSET, yo);
    write_reg(CFG_HOLDOFF, hold);
    stim_x_off = xo;
    stim_y_off = yo;
    stim_holdoff = hold;
  endtask

  task automatic run_phase(int idle_p, int stall_p, logic [15:0] xo, logic [15:0] yo,
                           logic [15:0] hold, int n, bit squeeze);
    set_regs(xo, yo, hold);
    send_idle_pct = idle_p;
    stall_pct = stall_p;
    // long receiver hold-off so the block backs up into the frame channel
    if (squeeze)
      hold_requests++;
    repeat (n) queue_random_frame();
    wait_drained();
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset defaults: the first two frames are held at zero heading, the third updates
    queue_frame(16'h0000, 16'h0000, 16'h0000, 32'd0);
    queue_frame(16'h1234, 16'hABCD, 16'h5678, 32'd299);
    queue_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd300);
    queue_frame(16'h0100, 16'h0001, 16'hFF00, 32'hFFFF_FFFF);  // backwards, held
    wait_drained();

    // plain axes, no hold-off
    set_regs(16'h0000, 16'h0000, 16'h0000);
    write_reg(CFG_UNUSED, 16'h1234);  // dropped by the block
    queue_frame(16'h0000, 16'h0000, 16'h0000, 32'd1000);  // zero vector
    queue_frame(16'h8000, 16'h7FFF, 16'h0000, 32'd1001);  // negative x axis
    queue_frame(16'h7FFF, 16'h8000, 16'h0000, 32'd1002);
    queue_frame(16'h0000, 16'h0001, 16'h7FFF, 32'd1003);
    queue_frame(16'h0000, 16'hFFFF, 16'h8000, 32'd1004);
    queue_frame(16'h8000, 16'h0000, 16'h8000, 32'd1005);
    queue_frame(16'h8000, 16'h00FF, 16'h7FFF, 32'd1006);
    queue_frame(16'hFFFF, 16'hFF00, 16'h0000, 32'd1007);  // x = -1 on the axis
    queue_frame(16'hFFFF, 16'h5555, 16'hFFFF, 32'd1008);
    queue_frame(16'h0001, 16'hAAAA, 16'hFFFF, 32'd1009);
    queue_frame(16'h0001, 16'h0000, 16'h0001, 32'd1009);  // same stamp, still updates
    queue_frame(16'h7FFF, 16'h0000, 16'h7FFF, 32'd500);   // backwards, held
    queue_frame(16'hC000, 16'h0000, 16'h4000, 32'h8000_1009);
    queue_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    wait_drained();

    stamp_ms = 32'd5000;
    run_phase(0, 0, X_OFFSET_RST, Y_OFFSET_RST, HOLDOFF_RST, 150, 1'b0);
    run_phase(50, 0, 16'h7FFF, 16'h8000, 16'h0000, 150, 1'b0);
    run_phase(0, 50, 16'h8000, 16'h7FFF, 16'hFFFF, 150, 1'b0);
    run_phase(20, 20, 16'($urandom()), 16'($urandom()), 16'($urandom()), 150, 1'b0);
    run_phase(0, 0, 16'h0000, 16'h0000, 16'h0001, 150, 1'b1);
    run_phase(50, 0, 16'($urandom()), 16'($urandom()), 16'($urandom_range(2000)), 150, 1'b0);
    run_phase(0, 50, 16'($urandom()), 16'($urandom()), 16'($urandom_range(500)), 150, 1'b0);
    run_phase(20, 20, 16'($urandom()), 16'($urandom()), 16'($urandom()), 200, 1'b0);

    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
